@@ rtl/core/mmcsr_pkg.sv @@
// shared constants for the machine-mode csr and trap unit
`timescale 1ns / 1ps

package mmcsr_pkg;

   // request kinds
   localparam logic [2:0] REQ_CSR     = 3'd0;
   localparam logic [2:0] REQ_SYSTEM  = 3'd1;
   localparam logic [2:0] REQ_EXCEPT  = 3'd2;
   localparam logic [2:0] REQ_IRQ     = 3'd3;
   localparam logic [2:0] REQ_PENDING = 3'd4;

   // funct3 codes
   localparam logic [2:0] FUNCT_SYSTEM  = 3'd0;
   localparam logic [2:0] FUNCT_ILLEGAL = 3'd4;
   localparam logic [1:0] OP_RW         = 2'd1;
   localparam logic [1:0] OP_SET        = 2'd2;

   // system codes
   localparam logic [11:0] SYS_ECALL  = 12'h000;
   localparam logic [11:0] SYS_EBREAK = 12'h001;
   localparam logic [11:0] SYS_ERET   = 12'h100;
   localparam logic [11:0] SYS_WFI    = 12'h102;

   // csr map
   localparam logic [11:0] CSR_MSTATUS   = 12'h300;
   localparam logic [11:0] CSR_MTVEC     = 12'h301;
   localparam logic [11:0] CSR_MIE       = 12'h304;
   localparam logic [11:0] CSR_MEPC      = 12'h341;
   localparam logic [11:0] CSR_MCAUSE    = 12'h342;
   localparam logic [11:0] CSR_MBADADDR  = 12'h343;
   localparam logic [11:0] CSR_MIP       = 12'h344;
   localparam logic [11:0] CSR_MTOHOST   = 12'h780;
   localparam logic [11:0] CSR_MFROMHOST = 12'h781;
   localparam logic [11:0] CSR_MHARTID   = 12'hF10;

   // cause codes
   localparam logic [63:0] CAUSE_ILLEGAL    = 64'd2;
   localparam logic [63:0] CAUSE_BREAKPOINT = 64'd3;

   // masks and reset values
   localparam logic [63:0] STATUS_WMASK   = 64'h0000_0000_003F_FFF9;
   localparam logic [63:0] STATUS_FORCE   = 64'h0000_0000_0000_0006;
   localparam logic [63:0] CAUSE_WMASK    = 64'h8000_0000_0000_000F;
   localparam logic [63:0] IRQ_M_MASK     = 64'h8888_8888_8888_8888;
   localparam logic [63:0] UNSUPPORTED    = 64'hCCCC_CCCC_CCCC_CCCC;
   localparam logic [63:0] STATUS_RESET   = 64'h0000_0000_0000_0DD6;
   localparam logic [63:0] TVEC_RESET     = 64'hFFFF_FFFF_FFFF_FE00;
   localparam logic [11:0] ERET_STACK_SET = 12'h206;

   // address of the hart id register on the csr port
   localparam logic [1:0] REG_HART_ID = 2'd0;

endpackage

@@ rtl/core/machine_mode_csr_trap_unit.sv @@
// machine-mode csr file, trap and interrupt dispatch, host command post
//
//   channel | direction | handshake                 | payload
//   req     | in        | req_valid / req_ready     | type, funct, csr addr, rs1, pc, cause, irq
//   rsp     | out       | rsp_valid / rsp_ready     | rd, redirect and target, host command
//   csr     | in        | psel, penable, pwrite     | hart id at byte address 0
//
// one transaction per cycle sustained while rsp_ready keeps the result moving; an accepted
// request passes through one input register, single-pass csr and trap logic, and the result register
// reset is synchronous and active high; all csrs take their reset values at once
// a stalled rsp holds the result and the input register; the input register drains only into a free result slot
`timescale 1ns / 1ps

module machine_mode_csr_trap_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_op_funct,
   input  logic [11:0] req_csr_addr,
   input  logic [4:0]  req_src_index,
   input  logic [63:0] req_src_value,
   input  logic [63:0] req_inst_pc,
   input  logic [3:0]  req_exc_cause,
   input  logic [63:0] req_irq_lines,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_rd_write,
   output logic [63:0] rsp_rd_value,
   output logic        rsp_redirect,
   output logic [63:0] rsp_target_pc,
   output logic        rsp_host_cmd_valid,
   output logic [63:0] rsp_host_cmd_addr,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mmcsr_pkg::*;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [2:0]  s1_type_ff;
   logic [2:0]  s1_funct_ff;
   logic [11:0] s1_addr_ff;
   logic [4:0]  s1_index_ff;
   logic [63:0] s1_value_ff;
   logic [63:0] s1_pc_ff;
   logic [3:0]  s1_cause_ff;
   logic [63:0] s1_lines_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rd_write_ff, rd_write_in;
   logic [63:0] rd_value_ff, rd_value_in;
   logic        redirect_ff, redirect_in;
   logic [63:0] target_ff, target_in;
   logic        host_valid_ff, host_valid_in;
   logic [63:0] host_addr_ff, host_addr_in;

   // architectural state
   logic [9:0]  hart_id_ff, hart_id_in;
   logic [63:0] status_ff, status_in;
   logic [63:0] tvec_ff, tvec_in;
   logic [63:0] epc_ff, epc_in;
   logic [63:0] badaddr_ff, badaddr_in;
   logic [63:0] cause_ff, cause_in;
   logic [63:0] enable_ff, enable_in;
   logic [63:0] tohost_ff, tohost_in;
   logic [63:0] fromhost_ff, fromhost_in;
   logic [63:0] pending_ff, pending_in;

   logic        advance;
   logic        cfg_write;
   logic [2:0]  eff_type;
   logic [63:0] csr_old;
   logic [63:0] operand;
   logic [63:0] wdata;
   logic        csr_wen;
   logic        trap_take;
   logic [63:0] trap_cause;
   logic [63:0] irq_mask;
   logic        irq_hit;
   logic [3:0]  irq_num;
   logic [11:0] trap_stack;
   logic [11:0] eret_stack;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_HART_ID) ? {22'd0, hart_id_ff} : 32'd0;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rd_write       = rd_write_ff;
   assign rsp_rd_value       = rd_value_ff;
   assign rsp_redirect       = redirect_ff;
   assign rsp_target_pc      = target_ff;
   assign rsp_host_cmd_valid = host_valid_ff;
   assign rsp_host_cmd_addr  = host_addr_ff;

   assign eff_type = (s1_type_ff == REQ_CSR && s1_funct_ff == FUNCT_SYSTEM) ? REQ_SYSTEM
                                                                           : s1_type_ff;

   // csr read
   always_comb begin
      case (s1_addr_ff)
         CSR_MHARTID:   csr_old = {54'd0, hart_id_ff};
         CSR_MSTATUS:   csr_old = status_ff;
         CSR_MTVEC:     csr_old = tvec_ff;
         CSR_MEPC:      csr_old = epc_ff;
         CSR_MBADADDR:  csr_old = badaddr_ff;
         CSR_MCAUSE:    csr_old = cause_ff;
         CSR_MTOHOST:   csr_old = tohost_ff;
         CSR_MFROMHOST: csr_old = fromhost_ff;
         CSR_MIE:       csr_old = enable_ff;
         CSR_MIP:       csr_old = pending_ff;
         default:       csr_old = UNSUPPORTED;
      endcase
   end

   assign operand = s1_funct_ff[2] ? {59'd0, s1_index_ff} : s1_value_ff;

   always_comb begin
      case (s1_funct_ff[1:0])
         OP_RW:   wdata = operand;
         OP_SET:  wdata = csr_old | operand;
         default: wdata = csr_old & ~operand;
      endcase
   end

   // lowest enabled pending interrupt wins
   assign irq_mask = status_ff[0] ? (pending_ff & enable_ff & IRQ_M_MASK) : 64'd0;
   always_comb begin
      irq_hit = 1'b0;
      irq_num = 4'd0;
      for (int n = 15; n >= 0; n--) begin
         if (irq_mask[4 * n + 3]) begin
            irq_hit = 1'b1;
            irq_num = 4'(n);
         end
      end
   end

   assign trap_stack = {status_ff[8:0], 3'b110};
   assign eret_stack = {3'b000, status_ff[11:3]} | ERET_STACK_SET;

   // decode
   always_comb begin
      rd_write_in   = 1'b0;
      rd_value_in   = 64'd0;
      redirect_in   = 1'b0;
      target_in     = 64'd0;
      host_valid_in = 1'b0;
      host_addr_in  = 64'd0;
      csr_wen       = 1'b0;
      trap_take     = 1'b0;
      trap_cause    = 64'd0;
      status_in     = status_ff;
      tvec_in       = tvec_ff;
      epc_in        = epc_ff;
      badaddr_in    = badaddr_ff;
      cause_in      = cause_ff;
      enable_in     = enable_ff;
      tohost_in     = tohost_ff;
      fromhost_in   = fromhost_ff;
      pending_in    = pending_ff;

      case (eff_type)
         REQ_CSR: begin
            if (s1_funct_ff == FUNCT_ILLEGAL) begin
               trap_take  = 1'b1;
               trap_cause = CAUSE_ILLEGAL;
            end else begin
               rd_write_in = 1'b1;
               rd_value_in = csr_old;
               csr_wen     = (s1_index_ff != 5'd0);
            end
         end
         REQ_SYSTEM: begin
            case (s1_addr_ff)
               SYS_ECALL: begin
                  trap_take  = 1'b1;
                  trap_cause = {60'd0, 2'b10, status_ff[2:1]};
               end
               SYS_EBREAK: begin
                  trap_take  = 1'b1;
                  trap_cause = CAUSE_BREAKPOINT;
               end
               SYS_ERET: begin
                  status_in   = {status_ff[63:12], eret_stack};
                  redirect_in = 1'b1;
                  target_in   = epc_ff;
               end
               SYS_WFI: begin
               end
               default: begin
                  trap_take  = 1'b1;
                  trap_cause = CAUSE_ILLEGAL;
               end
            endcase
         end
         REQ_EXCEPT: begin
            trap_take  = 1'b1;
            trap_cause = {60'd0, s1_cause_ff};
         end
         REQ_IRQ: begin
            trap_take  = irq_hit;
            trap_cause = {1'b1, 59'd0, irq_num};
         end
         REQ_PENDING: begin
            pending_in = {s1_lines_ff[63:4], pending_ff[3:0]};
         end
         default: begin
         end
      endcase

      if (csr_wen) begin
         case (s1_addr_ff)
            CSR_MSTATUS:  status_in  = (wdata & STATUS_WMASK) | STATUS_FORCE;
            CSR_MTVEC:    tvec_in    = {wdata[63:9], 9'd0};
            CSR_MEPC:     epc_in     = wdata;
            CSR_MBADADDR: badaddr_in = wdata;
            CSR_MCAUSE:   cause_in   = wdata & CAUSE_WMASK;
            CSR_MIE:      enable_in  = wdata & IRQ_M_MASK;
            CSR_MIP:      pending_in = {pending_ff[63:4], wdata[3], 3'd0};
            CSR_MTOHOST: begin
               tohost_in = wdata;
               if (fromhost_ff != wdata) begin
                  host_valid_in = 1'b1;
                  host_addr_in  = {wdata[63:3], 3'd0};
                  fromhost_in   = wdata;
               end
            end
            default: begin
            end
         endcase
      end

      if (trap_take) begin
         cause_in    = trap_cause;
         epc_in      = s1_pc_ff;
         badaddr_in  = s1_pc_ff;
         status_in   = {status_ff[63:17], 1'b0, status_ff[15:12], trap_stack};
         redirect_in = 1'b1;
         target_in   = tvec_ff + {56'd0, status_ff[2:1], 6'd0};
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      hart_id_in = cfg_write && csr_paddr == REG_HART_ID ? csr_pwdata[9:0] : hart_id_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hart_id_ff   <= 10'd0;
         status_ff    <= STATUS_RESET;
         tvec_ff      <= TVEC_RESET;
         epc_ff       <= 64'd0;
         badaddr_ff   <= 64'd0;
         cause_ff     <= 64'd0;
         enable_ff    <= 64'd0;
         tohost_ff    <= 64'd0;
         fromhost_ff  <= 64'd0;
         pending_ff   <= 64'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hart_id_ff   <= hart_id_in;
         if (advance) begin
            status_ff   <= status_in;
            tvec_ff     <= tvec_in;
            epc_ff      <= epc_in;
            badaddr_ff  <= badaddr_in;
            cause_ff    <= cause_in;
            enable_ff   <= enable_in;
            tohost_ff   <= tohost_in;
            fromhost_ff <= fromhost_in;
            pending_ff  <= pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_type_ff  <= req_type;
         s1_funct_ff <= req_op_funct;
         s1_addr_ff  <= req_csr_addr;
         s1_index_ff <= req_src_index;
         s1_value_ff <= req_src_value;
         s1_pc_ff    <= req_inst_pc;
         s1_cause_ff <= req_exc_cause;
         s1_lines_ff <= req_irq_lines;
      end
      if (advance) begin
         rd_write_ff   <= rd_write_in;
         rd_value_ff   <= rd_value_in;
         redirect_ff   <= redirect_in;
         target_ff     <= target_in;
         host_valid_ff <= host_valid_in;
         host_addr_ff  <= host_addr_in;
      end
   end

   // mstatus bits 1 and 2 are hardwired high
   a_status_fixed: assert property (@(posedge clock) disable iff (reset)
      status_ff[2:1] == 2'b11)
      else $error("mstatus fixed bits lost");

   a_tvec_aligned: assert property (@(posedge clock) disable iff (reset)
      tvec_ff[8:0] == 9'd0)
      else $error("mtvec not aligned");

   // a tohost write always copies into fromhost
   a_host_echo: assert property (@(posedge clock) disable iff (reset)
      tohost_ff == fromhost_ff)
      else $error("fromhost does not echo tohost");

   a_host_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_host_cmd_valid |-> rsp_host_cmd_addr[2:0] == 3'd0)
      else $error("host command address misaligned");

   a_no_double: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("transaction lost between stages");

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for the machine-mode csr and trap unit
`timescale 1ns / 1ps

module tb;
   import mmcsr_pkg::*;

   localparam logic [2:0] F_RW     = 3'd1;
   localparam logic [2:0] F_SET    = 3'd2;
   localparam logic [2:0] F_CLEAR  = 3'd3;
   localparam logic [2:0] F_RWI    = 3'd5;
   localparam logic [2:0] F_SETI   = 3'd6;
   localparam logic [2:0] F_CLEARI = 3'd7;
   localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
   localparam logic [11:0] CSR_ABSENT = 12'hFFF;
   localparam logic [11:0] SYS_BOGUS  = 12'hFFF;
   localparam logic [63:0] CAUSE_ECALL_BASE = 64'd8;
   localparam logic [63:0] CAUSE_IRQ_FLAG   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] TVEC_WMASK       = ~64'h1FF;
   localparam logic [63:0] ONES             = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [10*12-1:0] CSR_LIST = {CSR_MSTATUS, CSR_MTVEC, CSR_MIE, CSR_MEPC,
      CSR_MCAUSE, CSR_MBADADDR, CSR_MIP, CSR_MTOHOST, CSR_MFROMHOST, CSR_MHARTID};
   localparam logic [6*3-1:0] FUNCT_LIST = {F_RW, F_SET, F_CLEAR, F_RWI, F_SETI, F_CLEARI};
   localparam logic [4*12-1:0] SYS_LIST = {SYS_ECALL, SYS_EBREAK, SYS_ERET, SYS_WFI};
   localparam int CYCLE_LIMIT = 600000;
   localparam int LONG_HOLD = 300;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  funct;
      logic [11:0] addr;
      logic [4:0]  rs1;
      logic [63:0] rs1_value;
      logic [63:0] pc;
      logic [3:0]  cause;
      logic [63:0] lines;
   } csr_req_type;

   typedef struct packed {
      logic        rd_write;
      logic [63:0] rd_value;
      logic        redirect;
      logic [63:0] target_pc;
      logic        host_valid;
      logic [63:0] host_addr;
   } csr_rsp_type;

   class csr_scoreboard;
      logic [9:0]  hart_id;
      logic [63:0] mstatus_q, mtvec_q, mepc_q, mbadaddr_q, mcause_q;
      logic [63:0] mie_q, mtohost_q, mfromhost_q, mip_q;
      csr_rsp_type expected_rsp[$];
      int          errors, noted, checked, redirects, host_cmds;

      function new();
         hart_id = '0;
         mstatus_q = STATUS_RESET;
         mtvec_q = TVEC_RESET;
         mepc_q = '0;
         mbadaddr_q = '0;
         mcause_q = '0;
         mie_q = '0;
         mtohost_q = '0;
         mfromhost_q = '0;
         mip_q = '0;
         errors = 0;
         noted = 0;
         checked = 0;
         redirects = 0;
         host_cmds = 0;
      endfunction

      function void report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch %s: got %h want %h (response %0d)", what, got, want, checked);
         errors++;
      endfunction

      function int outstanding();
         return expected_rsp.size();
      endfunction

      function logic [63:0] read_csr(logic [11:0] addr);
         case (addr)
            CSR_MHARTID:   return {54'd0, hart_id};
            CSR_MSTATUS:   return mstatus_q;
            CSR_MTVEC:     return mtvec_q;
            CSR_MEPC:      return mepc_q;
            CSR_MBADADDR:  return mbadaddr_q;
            CSR_MCAUSE:    return mcause_q;
            CSR_MTOHOST:   return mtohost_q;
            CSR_MFROMHOST: return mfromhost_q;
            CSR_MIE:       return mie_q;
            CSR_MIP:       return mip_q;
            default:       return UNSUPPORTED;
         endcase
      endfunction

      function void write_csr(logic [11:0] addr, logic [63:0] v, inout csr_rsp_type res);
         case (addr)
            CSR_MSTATUS:  mstatus_q = (v & STATUS_WMASK) | STATUS_FORCE;
            CSR_MTVEC:    mtvec_q = v & TVEC_WMASK;
            CSR_MEPC:     mepc_q = v;
            CSR_MBADADDR: mbadaddr_q = v;
            CSR_MCAUSE:   mcause_q = v & CAUSE_WMASK;
            CSR_MIE:      mie_q = v & IRQ_M_MASK;
            CSR_MIP:      mip_q = (mip_q & ~64'hF) | (v & 64'h8);
            CSR_MTOHOST: begin
               mtohost_q = v;
               if (mfromhost_q != mtohost_q) begin
                  res.host_valid = 1'b1;
                  res.host_addr = mtohost_q & ~64'h7;
                  mfromhost_q = mtohost_q;
               end
            end
            default: ;
         endcase
      endfunction

      function void take_trap(logic [63:0] cause, logic [63:0] pc, inout csr_rsp_type res);
         logic [63:0] stack, offset;
         stack = ((mstatus_q & 64'h1FF) << 3) | STATUS_FORCE;
         offset = (stack & 64'h30) << 2;
         mcause_q = cause;
         mepc_q = pc;
         mbadaddr_q = pc;
         mstatus_q = ((mstatus_q & ~64'hFFF) | stack) & ~64'h10000;
         res.redirect = 1'b1;
         res.target_pc = mtvec_q + offset;
      endfunction

      function csr_rsp_type csr_unit_response(csr_req_type r);
         csr_rsp_type res;
         logic [2:0]  kind;
         logic [63:0] old_value, operand, irq_mask, stack, irq_num;
         logic        taken;
         res = '0;
         kind = r.kind;
         if (kind == REQ_CSR && r.funct == FUNCT_SYSTEM) kind = REQ_SYSTEM;
         case (kind)
            REQ_CSR: begin
               if (r.funct == FUNCT_ILLEGAL) begin
                  take_trap(CAUSE_ILLEGAL, r.pc, res);
               end else begin
                  old_value = read_csr(r.addr);
                  res.rd_write = 1'b1;
                  res.rd_value = old_value;
                  if (r.rs1 != 5'd0) begin
                     operand = r.funct[2] ? {59'd0, r.rs1} : r.rs1_value;
                     case (r.funct[1:0])
                        OP_RW:   write_csr(r.addr, operand, res);
                        OP_SET:  write_csr(r.addr, old_value | operand, res);
                        default: write_csr(r.addr, old_value & ~operand, res);
                     endcase
                  end
               end
            end
            REQ_SYSTEM: begin
               case (r.addr)
                  SYS_ECALL:
                     take_trap(CAUSE_ECALL_BASE + ((mstatus_q & 64'h6) >> 1), r.pc, res);
                  SYS_EBREAK: take_trap(CAUSE_BREAKPOINT, r.pc, res);
                  SYS_ERET: begin
                     stack = ((mstatus_q & 64'hFF8) >> 3) | {52'd0, ERET_STACK_SET};
                     mstatus_q = (mstatus_q & ~64'hFFF) | stack;
                     res.redirect = 1'b1;
                     res.target_pc = mepc_q;
                  end
                  SYS_WFI: ;
                  default: take_trap(CAUSE_ILLEGAL, r.pc, res);
               endcase
            end
            REQ_EXCEPT: take_trap({60'd0, r.cause}, r.pc, res);
            REQ_IRQ: begin
               irq_mask = mstatus_q[0] ? (mip_q & mie_q & IRQ_M_MASK) : 64'd0;
               taken = 1'b0;
               for (irq_num = 0; irq_num < 16; irq_num++) begin
                  if (!taken && irq_mask[irq_num * 4 + 3]) begin
                     take_trap(CAUSE_IRQ_FLAG | irq_num, r.pc, res);
                     taken = 1'b1;
                  end
               end
            end
            REQ_PENDING: mip_q = (mip_q & 64'hF) | (r.lines & ~64'hF);
            default: ;
         endcase
         return res;
      endfunction

      function void note_request(csr_req_type r);
         expected_rsp.push_back(csr_unit_response(r));
         noted++;
      endfunction

      function void check_response(csr_rsp_type got);
         csr_rsp_type want;
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected response", {63'd0, got.redirect}, 64'd0);
            return;
         end
         want = expected_rsp.pop_front();
         if (got.rd_write !== want.rd_write)
            report_mismatch("rd_write", {63'd0, got.rd_write}, {63'd0, want.rd_write});
         if (got.rd_value !== want.rd_value)
            report_mismatch("rd_value", got.rd_value, want.rd_value);
         if (got.redirect !== want.redirect)
            report_mismatch("redirect", {63'd0, got.redirect}, {63'd0, want.redirect});
         if (got.target_pc !== want.target_pc)
            report_mismatch("target_pc", got.target_pc, want.target_pc);
         if (got.host_valid !== want.host_valid)
            report_mismatch("host_cmd_valid", {63'd0, got.host_valid},
                            {63'd0, want.host_valid});
         if (got.host_addr !== want.host_addr)
            report_mismatch("host_cmd_addr", got.host_addr, want.host_addr);
         if (want.redirect) redirects++;
         if (want.host_valid) host_cmds++;
         checked++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type = '0;
   logic [2:0]  req_op_funct = '0;
   logic [11:0] req_csr_addr = '0;
   logic [4:0]  req_src_index = '0;
   logic [63:0] req_src_value = '0;
   logic [63:0] req_inst_pc = '0;
   logic [3:0]  req_exc_cause = '0;
   logic [63:0] req_irq_lines = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_rd_write;
   logic [63:0] rsp_rd_value;
   logic        rsp_redirect;
   logic [63:0] rsp_target_pc;
   logic        rsp_host_cmd_valid;
   logic [63:0] rsp_host_cmd_addr;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   csr_scoreboard sb;
   bit hold_off = 1'b0;
   int cycle_count = 0;
   int hart_settings = 0;

   machine_mode_csr_trap_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_type(req_type), .req_op_funct(req_op_funct), .req_csr_addr(req_csr_addr),
      .req_src_index(req_src_index), .req_src_value(req_src_value),
      .req_inst_pc(req_inst_pc), .req_exc_cause(req_exc_cause),
      .req_irq_lines(req_irq_lines),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_rd_write(rsp_rd_write), .rsp_rd_value(rsp_rd_value),
      .rsp_redirect(rsp_redirect), .rsp_target_pc(rsp_target_pc),
      .rsp_host_cmd_valid(rsp_host_cmd_valid), .rsp_host_cmd_addr(rsp_host_cmd_addr),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      logic [31:0] hi, lo;
      hi = $urandom;
      lo = $urandom;
      return {hi, lo};
   endfunction

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic csr_req_type mk(logic [2:0] kind, logic [2:0] funct, logic [11:0] addr,
                                      logic [4:0] rs1, logic [63:0] value, logic [63:0] pc,
                                      logic [3:0] cause, logic [63:0] lines);
      csr_req_type r;
      r.kind = kind;
      r.funct = funct;
      r.addr = addr;
      r.rs1 = rs1;
      r.rs1_value = value;
      r.pc = pc;
      r.cause = cause;
      r.lines = lines;
      return r;
   endfunction

   function automatic csr_req_type random_request();
      csr_req_type r;
      logic [63:0] noise;
      int          pick;
      noise = rand64();
      r.funct = noise[2:0];
      r.addr = ($urandom_range(0, 99) < 85) ? CSR_LIST[$urandom_range(0, 9) * 12 +: 12]
                                            : noise[14:3];
      r.rs1 = (noise[17:15] == 3'd0) ? 5'd0 : noise[22:18];
      r.cause = noise[26:23];
      pick = $urandom_range(0, 9);
      r.rs1_value = (pick == 0) ? ONES : (pick == 1) ? 64'd0 : rand64();
      r.pc = rand64();
      r.lines = rand64();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         r.kind = REQ_CSR;
         if ($urandom_range(0, 19) != 0) r.funct = FUNCT_LIST[$urandom_range(0, 5) * 3 +: 3];
      end else if (pick < 70) begin
         r.kind = REQ_SYSTEM;
         r.addr = ($urandom_range(0, 99) < 85) ? SYS_LIST[$urandom_range(0, 3) * 12 +: 12]
                                               : noise[38:27];
      end else if (pick < 78) begin
         r.kind = REQ_EXCEPT;
      end else if (pick < 90) begin
         r.kind = REQ_IRQ;
      end else if (pick < 97) begin
         r.kind = REQ_PENDING;
      end else begin
         r.kind = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
      end
      return r;
   endfunction

   function automatic csr_req_type shaped(logic [2:0] kind, logic [2:0] funct,
                                          logic [11:0] addr, logic [4:0] rs1);
      csr_req_type r;
      r = random_request();
      r.kind = kind;
      r.funct = funct;
      r.addr = addr;
      r.rs1 = rs1;
      return r;
   endfunction

   task automatic send_item(csr_req_type item, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= item.kind;
      req_op_funct <= item.funct;
      req_csr_addr <= item.addr;
      req_src_index <= item.rs1;
      req_src_value <= item.rs1_value;
      req_inst_pc <= item.pc;
      req_exc_cause <= item.cause;
      req_irq_lines <= item.lines;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_hart_id(logic [9:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_HART_ID;
      csr_pwdata <= {22'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.hart_id = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_psel <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {22'd0, value})
         sb.report_mismatch("hart id readback", {32'd0, csr_prdata}, {54'd0, value});
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      hart_settings++;
   endtask

   task automatic run_directed();
      csr_req_type items[$];
      items.push_back(mk(REQ_CSR, F_SET, CSR_MHARTID, 5'd0, ONES, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_CSR, F_RW, CSR_MSTATUS, 5'd31, ONES, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_CSR, F_RW, CSR_MTVEC, 5'd1, ONES, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_CSR, F_RW, CSR_MIE, 5'd31, ONES, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_CSR, F_SETI, CSR_MIP, 5'd31, 64'd0, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_PENDING, F_RW, 12'd0, 5'd0, 64'd0, 64'd0, 4'd0, ONES));
      items.push_back(mk(REQ_IRQ, F_RW, 12'd0, 5'd0, 64'd0, ONES, 4'd0, 64'd0));
      items.push_back(mk(REQ_SYSTEM, FUNCT_SYSTEM, SYS_ERET, 5'd0, 64'd0, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_CSR, F_CLEARI, CSR_MSTATUS, 5'd1, 64'd0, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_CSR, F_RW, CSR_MEPC, 5'd5, 64'h0123_4567_89AB_CDEF, 64'd0,
                         4'd0, 64'd0));
      items.push_back(mk(REQ_SYSTEM, FUNCT_SYSTEM, SYS_ERET, 5'd0, 64'd0, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_SYSTEM, FUNCT_SYSTEM, SYS_ECALL, 5'd0, 64'd0, ONES, 4'd0, 64'd0));
      items.push_back(mk(REQ_CSR, FUNCT_SYSTEM, SYS_EBREAK, 5'd0, 64'd0, 64'h40, 4'd0, 64'd0));
      items.push_back(mk(REQ_SYSTEM, FUNCT_SYSTEM, SYS_WFI, 5'd0, 64'd0, 64'h80, 4'd0, 64'd0));
      items.push_back(mk(REQ_SYSTEM, F_CLEARI, SYS_BOGUS, 5'd31, ONES, 64'h100, 4'hF, ONES));
      items.push_back(mk(REQ_CSR, FUNCT_ILLEGAL, CSR_MSTATUS, 5'd7, ONES, 64'h200, 4'd0,
                         64'd0));
      items.push_back(mk(REQ_EXCEPT, F_RW, 12'd0, 5'd0, 64'd0, 64'd0, 4'hF, 64'd0));
      items.push_back(mk(REQ_CSR, F_RW, CSR_MTOHOST, 5'd1, ONES, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_CSR, F_RW, CSR_MTOHOST, 5'd1, ONES, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_CSR, F_RW, CSR_MFROMHOST, 5'd2, 64'd0, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_CSR, F_RW, CSR_MHARTID, 5'd3, 64'd0, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_CSR, F_SET, CSR_ABSENT, 5'd4, ONES, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_CSR, F_RW, CSR_MCAUSE, 5'd9, ONES, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_CSR, F_RW, CSR_MBADADDR, 5'd9, ONES, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_UNUSED_LAST, F_CLEARI, CSR_ABSENT, 5'd31, ONES, ONES, 4'hF, ONES));
      items.push_back(mk(REQ_CSR, F_CLEAR, CSR_MIE, 5'd1, ONES, 64'd0, 4'd0, 64'd0));
      items.push_back(mk(REQ_IRQ, F_RW, 12'd0, 5'd0, 64'd0, 64'h1000, 4'd0, 64'd0));
      foreach (items[i]) send_item(items[i], 0);
   endtask

   task automatic run_random(int count);
      csr_req_type seq[$];
      int       sent, gap, pick;
      logic [4:0] rs1_nz;
      sent = 0;
      while (sent < count) begin
         seq.delete();
         pick = $urandom_range(0, 9);
         rs1_nz = 5'($urandom_range(1, 31));
         if (pick < 2) begin
            // interrupt setup, dispatch and return
            seq.push_back(shaped(REQ_CSR, F_SETI, CSR_MSTATUS, 5'd1));
            seq.push_back(shaped(REQ_CSR, F_RW, CSR_MIE, rs1_nz));
            seq.push_back(shaped(REQ_PENDING, F_RW, 12'd0, 5'd0));
            if ($urandom_range(0, 1) == 0)
               seq.push_back(shaped(REQ_CSR, F_SETI, CSR_MIP, 5'd8));
            seq.push_back(shaped(REQ_IRQ, F_RW, 12'd0, 5'd0));
            seq.push_back(shaped(REQ_SYSTEM, FUNCT_SYSTEM, SYS_ERET, 5'd0));
         end else if (pick == 2) begin
            seq.push_back(shaped(REQ_CSR, F_RW, CSR_MTVEC, rs1_nz));
            seq.push_back(shaped(REQ_EXCEPT, F_RW, 12'd0, 5'd0));
            seq.push_back(shaped(REQ_CSR, F_SET, CSR_MEPC, 5'd0));
            seq.push_back(shaped(REQ_SYSTEM, FUNCT_SYSTEM, SYS_ERET, 5'd0));
         end else if (pick == 3) begin
            seq.push_back(shaped(REQ_CSR, F_RW, CSR_MTOHOST, rs1_nz));
            if ($urandom_range(0, 1) == 0) seq.push_back(seq[0]);
            seq.push_back(shaped(REQ_CSR, F_SET, CSR_MFROMHOST, 5'd0));
         end else begin
            seq.push_back(random_request());
         end
         foreach (seq[i]) begin
            gap = (((sent / 40) % 3) == 0) ? 0 : random_gap();
            send_item(seq[i], gap);
            sent++;
         end
      end
   endtask

   // response side backpressure
   initial begin
      int gap, held;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            for (held = 0; held < LONG_HOLD; held++) @(negedge clock);
            hold_off = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(8, 60)) @(negedge clock);
         end else begin
            gap = random_gap();
            if (gap == 0) begin
               rsp_ready <= 1'b1;
               @(negedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat (gap) @(negedge clock);
               rsp_ready <= 1'b1;
               @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response('{rsp_rd_write, rsp_rd_value, rsp_redirect, rsp_target_pc,
                             rsp_host_cmd_valid, rsp_host_cmd_addr});
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, sb.outstanding());
      $display("machine_mode_csr_trap_unit regression: fail");
      $finish;
   end

   initial begin
      int phase;
      logic [9:0] hart_value;
      sb = new();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_hart_id(10'h3FF);
      run_directed();
      wait_drain();
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       hart_value = 10'd0;
            2:       hart_value = 10'd1;
            default: hart_value = 10'($urandom);
         endcase
         write_hart_id(hart_value);
         if (phase == 1) begin
            run_random(150);
            hold_off = 1'b1;
            run_random(275);
         end else if (phase == 2) begin
            run_random(200);
            wait_drain();
            run_random(225);
         end else begin
            run_random(425);
         end
         wait_drain();
      end
      repeat (8) @(posedge clock);
      $display("summary: %0d transactions sent, %0d responses checked, %0d redirects, %0d %s",
               sb.noted, sb.checked, sb.redirects, sb.host_cmds, "host commands");
      $display("summary: %0d hart id settings, long response stall and mid-run drain, %0d %s",
               hart_settings, cycle_count, "cycles");
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("machine_mode_csr_trap_unit regression: pass");
      end else begin
         $display("%0d mismatches, %0d responses outstanding", sb.errors, sb.outstanding());
         $display("machine_mode_csr_trap_unit regression: fail");
      end
      $finish;
   end

endmodule

@@ machine_mode_csr_trap_unit.f @@
rtl/core/mmcsr_pkg.sv
rtl/core/machine_mode_csr_trap_unit.sv
tb/sv/tb.sv
